// ===== rtl/blinn_phong_reflectance_map_assert.svh =====
// Assertion macros shared by the reflectance map RTL
`ifndef BLINN_PHONG_REFLECTANCE_MAP_ASSERT_SVH
`define BLINN_PHONG_REFLECTANCE_MAP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BPRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bprm: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BPRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bprm: next-cycle check failed");

`endif

// ===== rtl/bprm_pkg.sv =====
// Shared types, constants, sine ROM and fixed-point helpers for the reflectance map
package bprm_pkg;

  localparam int FRAC_BITS = 15;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int ROM_W     = FRAC_BITS + 1;
  localparam int TRIG_W    = FRAC_BITS + 2;
  localparam int HALF_W    = TRIG_W + 1;
  localparam int SUMSQ_W   = 2 * HALF_W - 2;
  localparam int LEN_W     = SUMSQ_W / 2;
  localparam int COEF_W    = 15;
  localparam int ORDER_W   = 7;
  localparam int THETA_W   = 7;
  localparam int PHI_W     = 9;
  localparam int OUT_W     = 8;
  localparam int BASE_W    = COEF_W + TRIG_W + 1;
  localparam int NUM_W     = BASE_W + 1;
  localparam int MX_W      = BASE_W - 1;
  localparam int DEG_W     = 10;
  localparam int ROM_DEPTH = 91;
  localparam int IDX_W     = 7;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam int DEG_QTR   = 90;
  localparam int DEG_HALF  = 180;
  localparam int DEG_3QTR  = 270;
  localparam int DEG_FULL  = 360;
  localparam int GRAY_MAX  = 255;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic [ROM_W-1:0] sin_rom_t [ROM_DEPTH];

  // Register map, one word per register
  typedef enum logic [2:0] {
    REG_IN_THETA  = 3'd0,
    REG_IN_PHI    = 3'd1,
    REG_AMBIENT   = 3'd2,
    REG_DIFFUSE   = 3'd3,
    REG_SPECULAR  = 3'd4,
    REG_SPEC_ORD  = 3'd5
  } cfg_reg_e;

  // Incident-ray terms that feed the half vector
  typedef struct packed {
    trig_t hxi;
    trig_t hzi;
    trig_t cti;
  } in_ray_t;

  // Brightness terms that depend only on configuration
  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic signed [BASE_W-1:0] mx;
    logic [COEF_W-1:0]        ks;
  } norm_cfg_t;

  // Sine of 0..89 degrees from a Q30 Taylor series, rounded to QF; 90 is exactly one
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t          rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    for (int a = 0; a < DEG_QTR; a++) begin
      x    = (64'(a) * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      rom[a] = ROM_W'((sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    rom[DEG_QTR] = ROM_W'(ONE_Q);
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_sin_rom();

  // Sine of any angle below two turns, by quadrant symmetry
  function automatic trig_t sin_deg(input logic [DEG_W-1:0] deg);
    logic [DEG_W-1:0] d;
    logic [DEG_W-1:0] r;
    logic             neg;
    trig_t            mag;
    d = (deg >= DEG_W'(DEG_FULL)) ? deg - DEG_W'(DEG_FULL) : deg;
    if (d <= DEG_W'(DEG_QTR)) begin
      r   = d;
      neg = 1'b0;
    end else if (d <= DEG_W'(DEG_HALF)) begin
      r   = DEG_W'(DEG_HALF) - d;
      neg = 1'b0;
    end else if (d <= DEG_W'(DEG_3QTR)) begin
      r   = d - DEG_W'(DEG_HALF);
      neg = 1'b1;
    end else begin
      r   = DEG_W'(DEG_FULL) - d;
      neg = 1'b1;
    end
    mag = trig_t'({1'b0, SIN_ROM[r[IDX_W-1:0]]});
    return neg ? -mag : mag;
  endfunction

  // QF product rounded toward minus infinity
  function automatic trig_t mul_q(input trig_t a, input trig_t b);
    logic signed [2*TRIG_W-1:0] prod;
    prod = a * b;
    return trig_t'(prod >>> FRAC_BITS);
  endfunction

endpackage

// ===== rtl/bprm_front.sv =====
// Outgoing ray lookup, half vector and its squared length
module bprm_front import bprm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [THETA_W-1:0]        theta_i,
  input  logic [PHI_W-1:0]          phi_i,
  input  in_ray_t                   ray_i,
  output logic                      valid_o,
  output logic [SUMSQ_W-1:0]        sumsq_o,
  output logic signed [HALF_W-1:0]  hy_o
);

  localparam int NSTG = 4;

  logic [NSTG-1:0]            vld_q;
  trig_t                      sto_q, cto_q, spo_q, cpo_q;
  logic signed [HALF_W-1:0]   hx_q, hy_q, hz_q, hy3_q, hy4_q;
  logic signed [2*HALF_W-1:0] sqx, sqy, sqz;
  logic [SUMSQ_W-2:0]         sqx_q, sqy_q, sqz_q;
  logic [SUMSQ_W-1:0]         sum_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  // Stage 1: sine and cosine of the outgoing angles
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sto_q <= sin_deg(DEG_W'(theta_i));
      cto_q <= sin_deg(DEG_W'(theta_i) + DEG_W'(DEG_QTR));
      spo_q <= sin_deg(DEG_W'(phi_i));
      cpo_q <= sin_deg(DEG_W'(phi_i) + DEG_W'(DEG_QTR));
    end
  end

  // Stage 2: half vector components
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hx_q <= HALF_W'(ray_i.hxi) + HALF_W'(mul_q(sto_q, cpo_q));
      hz_q <= HALF_W'(ray_i.hzi) + HALF_W'(mul_q(sto_q, spo_q));
      hy_q <= HALF_W'(ray_i.cti) + HALF_W'(cto_q);
    end
  end

  // Stage 3: squares
  assign sqx = hx_q * hx_q;
  assign sqy = hy_q * hy_q;
  assign sqz = hz_q * hz_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sqx_q <= sqx[SUMSQ_W-2:0];
      sqy_q <= sqy[SUMSQ_W-2:0];
      sqz_q <= sqz[SUMSQ_W-2:0];
      hy3_q <= hy_q;
    end
  end

  // Stage 4: sum of squares
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= SUMSQ_W'(sqx_q) + SUMSQ_W'(sqy_q) + SUMSQ_W'(sqz_q);
      hy4_q <= hy3_q;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign sumsq_o = sum_q;
  assign hy_o    = hy4_q;

endmodule

// ===== rtl/bprm_sqrt.sv =====
// Pipelined integer square root, two root bits per stage
module bprm_sqrt import bprm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [SUMSQ_W-1:0]        sumsq_i,
  input  logic signed [HALF_W-1:0]  hy_i,
  output logic                      valid_o,
  output logic [LEN_W-1:0]          len_o,
  output logic signed [HALF_W-1:0]  hy_o
);

  localparam int NIT   = LEN_W;
  localparam int PER   = 2;
  localparam int NST   = (NIT + PER - 1) / PER;
  localparam int REM_W = LEN_W + 4;

  logic [NST-1:0]           vld_q;
  logic [LEN_W-1:0]         root_q [NST];
  logic [REM_W-1:0]         rem_q  [NST];
  logic [SUMSQ_W-1:0]       rad_q  [NST];
  logic signed [HALF_W-1:0] hy_q   [NST];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [LEN_W-1:0]         root_in, root_d;
    logic [REM_W-1:0]         rem_in, rem_d, trial;
    logic [SUMSQ_W-1:0]       rad_in;
    logic signed [HALF_W-1:0] hy_in;

    if (s == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = sumsq_i;
      assign hy_in   = hy_i;
    end else begin : g_next
      assign root_in = root_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign hy_in   = hy_q[s-1];
    end

    // Bring down two radicand bits, try root*4+1, keep or drop
    always_comb begin
      root_d = root_in;
      rem_d  = rem_in;
      trial  = '0;
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < NIT) begin
          rem_d = {rem_d[REM_W-3:0], rad_in[2*(NIT-1-(s*PER+j)) +: 2]};
          trial = REM_W'({root_d, 2'b01});
          if (rem_d >= trial) begin
            rem_d  = rem_d - trial;
            root_d = {root_d[LEN_W-2:0], 1'b1};
          end else begin
            root_d = {root_d[LEN_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        root_q[s] <= root_d;
        rem_q[s]  <= rem_d;
        rad_q[s]  <= rad_in;
        hy_q[s]   <= hy_in;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign len_o   = root_q[NST-1];
  assign hy_o    = hy_q[NST-1];

endmodule

// ===== rtl/bprm_udiv.sv =====
// Pipelined division of the up component by the half vector length
module bprm_udiv import bprm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [LEN_W-1:0]          len_i,
  input  logic signed [HALF_W-1:0]  hy_i,
  output logic                      valid_o,
  output trig_t                     u_o
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int PER   = 2;
  localparam int NDS   = (QW + PER - 1) / PER;
  localparam int NST   = NDS + 2;
  localparam int DIV_W = LEN_W + QW;

  logic [NST-1:0]       vld_q;
  logic [HALF_W-2:0]    hy_mag;
  logic [DIV_W-1:0]     num0_q;
  logic [LEN_W-1:0]     len0_q;
  logic                 neg0_q, zero0_q;
  logic [DIV_W-1:0]     rem_q  [NDS];
  logic [QW-1:0]        quo_q  [NDS];
  logic [LEN_W-1:0]     len_q  [NDS];
  logic                 neg_q  [NDS];
  logic                 zero_q [NDS];
  trig_t                u_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // Setup: magnitude of the dividend, sign and zero length
  assign hy_mag = hy_i[HALF_W-1] ? (HALF_W-1)'(-hy_i) : (HALF_W-1)'(hy_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num0_q  <= DIV_W'(hy_mag) << FRAC_BITS;
      len0_q  <= len_i;
      neg0_q  <= hy_i[HALF_W-1];
      zero0_q <= (len_i == '0);
    end
  end

  for (genvar s = 0; s < NDS; s++) begin : g_step
    logic [DIV_W-1:0] rem_in, rem_d;
    logic [QW-1:0]    quo_in, quo_d;
    logic [LEN_W-1:0] len_in;
    logic             neg_in, zero_in;

    if (s == 0) begin : g_first
      assign rem_in  = num0_q;
      assign quo_in  = '0;
      assign len_in  = len0_q;
      assign neg_in  = neg0_q;
      assign zero_in = zero0_q;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign len_in  = len_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    // Restoring division, two quotient bits per stage
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < QW) begin
          if (rem_d >= (DIV_W'(len_in) << (QW - 1 - (s * PER + j)))) begin
            rem_d = rem_d - (DIV_W'(len_in) << (QW - 1 - (s * PER + j)));
            quo_d[QW-1-(s*PER+j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        len_q[s]  <= len_in;
        neg_q[s]  <= neg_in;
        zero_q[s] <= zero_in;
      end
    end
  end

  // Clamp to one, restore sign, force zero for a zero-length half vector
  logic [QW-1:0] quo_last;
  trig_t         u_mag;

  assign quo_last = quo_q[NDS-1];
  assign u_mag    = (quo_last > QW'(ONE_Q)) ? trig_t'(ONE_Q) : trig_t'({1'b0, quo_last});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (zero_q[NDS-1]) begin
        u_q <= '0;
      end else if (neg_q[NDS-1]) begin
        u_q <= -u_mag;
      end else begin
        u_q <= u_mag;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign u_o     = u_q;

endmodule

// ===== rtl/bprm_power.sv =====
// Chain of QF multiplier stages raising the up component to the specular order
module bprm_power import bprm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [ORDER_W-1:0] order_i,
  input  logic               valid_i,
  input  trig_t              u_i,
  output logic               valid_o,
  output trig_t              p_o
);

  localparam int NPW = (1 << ORDER_W) - 1;

  logic [NPW-1:0] vld_q;
  trig_t          u_q [NPW];
  trig_t          p_q [NPW];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NPW-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < NPW; s++) begin : g_mul
    trig_t u_in, p_in;

    if (s == 0) begin : g_first
      assign u_in = u_i;
      assign p_in = trig_t'(ONE_Q);
    end else begin : g_next
      assign u_in = u_q[s-1];
      assign p_in = p_q[s-1];
    end

    // Multiply only while this step is below the order, else pass through
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        u_q[s] <= u_in;
        p_q[s] <= (ORDER_W'(s) < order_i) ? mul_q(p_in, u_in) : p_in;
      end
    end
  end

  assign valid_o = vld_q[NPW-1];
  assign p_o     = p_q[NPW-1];

endmodule

// ===== rtl/bprm_norm.sv =====
// Brightness sum, division by the maximum and scaling to a gray level
module bprm_norm import bprm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  norm_cfg_t          cfg_i,
  input  logic               valid_i,
  input  trig_t              p_i,
  output logic               valid_o,
  output logic [OUT_W-1:0]   intensity_o,
  output logic               zero_range_o
);

  localparam int PER    = 2;
  localparam int NDV    = OUT_W / PER;
  localparam int NST    = NDV + 2;
  localparam int DIVD_W = MX_W + OUT_W;

  logic [NST-1:0]           vld_q;
  logic signed [NUM_W-1:0]  ksp;
  logic signed [NUM_W-1:0]  num_q;
  logic [DIVD_W-1:0]        numx;
  logic [DIVD_W-1:0]        rem0_q;
  logic                     pos0_q, sat0_q;
  logic [MX_W-1:0]          mx_u;
  logic                     mx_pos;
  logic [DIVD_W-1:0]        rem_q [NDV-1];
  logic [OUT_W-1:0]         quo_q [NDV-1];
  logic                     pos_q [NDV-1];
  logic                     sat_q [NDV-1];
  logic [OUT_W-1:0]         inten_q;
  logic                     zr_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // Stage 1: ks * p + base
  assign ksp = $signed({1'b0, cfg_i.ks}) * p_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q <= ksp + NUM_W'($signed(cfg_i.base));
    end
  end

  // Stage 2: classify and form num * 255
  assign numx   = DIVD_W'(num_q[MX_W-1:0]);
  assign mx_u   = cfg_i.mx[MX_W-1:0];
  assign mx_pos = !cfg_i.mx[BASE_W-1] && (cfg_i.mx != '0);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem0_q <= (numx << OUT_W) - numx;
      pos0_q <= !num_q[NUM_W-1] && (num_q != '0);
      sat0_q <= (num_q >= NUM_W'($signed(cfg_i.mx)));
    end
  end

  for (genvar s = 0; s < NDV; s++) begin : g_step
    logic [DIVD_W-1:0] rem_in, rem_d;
    logic [OUT_W-1:0]  quo_in, quo_d;
    logic              pos_in, sat_in;

    if (s == 0) begin : g_first
      assign rem_in = rem0_q;
      assign quo_in = '0;
      assign pos_in = pos0_q;
      assign sat_in = sat0_q;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign pos_in = pos_q[s-1];
      assign sat_in = sat_q[s-1];
    end

    // Restoring division by the maximum, two gray bits per stage
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < PER; j++) begin
        if (rem_d >= (DIVD_W'(mx_u) << (OUT_W - 1 - (s * PER + j)))) begin
          rem_d = rem_d - (DIVD_W'(mx_u) << (OUT_W - 1 - (s * PER + j)));
          quo_d[OUT_W-1-(s*PER+j)] = 1'b1;
        end
      end
    end

    if (s < NDV - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[s] <= rem_d;
          quo_q[s] <= quo_d;
          pos_q[s] <= pos_in;
          sat_q[s] <= sat_in;
        end
      end
    end else begin : g_last
      // Last stage: saturate, drop non-positive sums, flag a non-positive maximum
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          if (!mx_pos) begin
            inten_q <= '0;
            zr_q    <= 1'b1;
          end else if (!pos_in) begin
            inten_q <= '0;
            zr_q    <= 1'b0;
          end else if (sat_in) begin
            inten_q <= OUT_W'(GRAY_MAX);
            zr_q    <= 1'b0;
          end else begin
            inten_q <= quo_d;
            zr_q    <= 1'b0;
          end
        end
      end
    end
  end

  assign valid_o      = vld_q[NST-1];
  assign intensity_o  = inten_q;
  assign zero_range_o = zr_q;

endmodule

// ===== rtl/blinn_phong_reflectance_map.sv =====
// Top level of the Blinn-Phong reflectance map: register port and pixel pipeline
//
//   Port group    Direction  Handshake             Carries
//   input item    in         in_valid_i/in_stall_o out_theta_deg_i, out_phi_deg_i
//   result item   out        out_valid_o/out_stall_i intensity_o, zero_range_o
//   registers     in/out     psel/penable/pready   paddr, pwdata, prdata
//
// One pixel enters per cycle while the pipeline is not stalled.
// Latency is set mostly by the chain of 127 multiplier stages for the order.
// A held result stalls the whole pipeline; bubbles pass through unchanged.
// Most register writes reach the datapath through derived registers.
// Reset clears valid bits and restores the register defaults.
`include "blinn_phong_reflectance_map_assert.svh"
module blinn_phong_reflectance_map import bprm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [THETA_W-1:0]  out_theta_deg_i,
  input  logic [PHI_W-1:0]    out_phi_deg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    intensity_o,
  output logic                zero_range_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [THETA_W-1:0]       theta_q;
  logic [PHI_W-1:0]         phi_q;
  logic [COEF_W-1:0]        ka_q, kd_q, ks_q;
  logic [ORDER_W-1:0]       order_q;
  logic                     wr_en;
  logic                     wr_ord;
  cfg_reg_e                 reg_sel;
  trig_t                    sti_q, cti_q, spi_q, cpi_q;
  trig_t                    hxi_q, hzi_q;
  logic signed [BASE_W-1:0] kd_ct, base_d, base_q, mx_q;
  in_ray_t                  ray;
  norm_cfg_t                ncfg;
  logic                     adv;

  logic                     f_valid, s_valid, d_valid, p_valid;
  logic [SUMSQ_W-1:0]       f_sumsq;
  logic signed [HALF_W-1:0] f_hy, s_hy;
  logic [LEN_W-1:0]         s_len;
  trig_t                    d_u, p_pow;

  // Register port: write on the access phase, zero-wait
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_ord  = wr_en && (reg_sel == REG_SPEC_ORD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      theta_q <= '0;
      phi_q   <= '0;
      ka_q    <= COEF_W'(1638);
      kd_q    <= COEF_W'(1638);
      ks_q    <= COEF_W'(6554);
      order_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IN_THETA: theta_q <= pwdata[THETA_W-1:0];
        REG_IN_PHI:   phi_q   <= pwdata[PHI_W-1:0];
        REG_AMBIENT:  ka_q    <= pwdata[COEF_W-1:0];
        REG_DIFFUSE:  kd_q    <= pwdata[COEF_W-1:0];
        REG_SPECULAR: ks_q    <= pwdata[COEF_W-1:0];
        REG_SPEC_ORD: order_q <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_IN_THETA: prdata = DATA_W'(theta_q);
      REG_IN_PHI:   prdata = DATA_W'(phi_q);
      REG_AMBIENT:  prdata = DATA_W'(ka_q);
      REG_DIFFUSE:  prdata = DATA_W'(kd_q);
      REG_SPECULAR: prdata = DATA_W'(ks_q);
      REG_SPEC_ORD: prdata = DATA_W'(order_q);
      default:      prdata = '0;
    endcase
  end

  // Derived incident terms, first level: trig lookups
  always_ff @(posedge clk_i) begin
    sti_q <= sin_deg(DEG_W'(theta_q));
    cti_q <= sin_deg(DEG_W'(theta_q) + DEG_W'(DEG_QTR));
    spi_q <= sin_deg(DEG_W'(phi_q));
    cpi_q <= sin_deg(DEG_W'(phi_q) + DEG_W'(DEG_QTR));
  end

  // Derived incident terms, second level: ray products, base and maximum
  assign kd_ct  = $signed({1'b0, kd_q}) * cti_q;
  assign base_d = ($signed(BASE_W'(ka_q)) <<< FRAC_BITS) + kd_ct;

  always_ff @(posedge clk_i) begin
    hxi_q  <= mul_q(sti_q, cpi_q);
    hzi_q  <= mul_q(sti_q, spi_q);
    base_q <= base_d;
    mx_q   <= base_d + ($signed(BASE_W'(ks_q)) <<< FRAC_BITS);
  end

  assign ray.hxi   = hxi_q;
  assign ray.hzi   = hzi_q;
  assign ray.cti   = cti_q;
  assign ncfg.base = base_q;
  assign ncfg.mx   = mx_q;
  assign ncfg.ks   = ks_q;

  // Hold every stage while the result register is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  bprm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .theta_i (out_theta_deg_i),
    .phi_i   (out_phi_deg_i),
    .ray_i   (ray),
    .valid_o (f_valid),
    .sumsq_o (f_sumsq),
    .hy_o    (f_hy)
  );

  bprm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .sumsq_i (f_sumsq),
    .hy_i    (f_hy),
    .valid_o (s_valid),
    .len_o   (s_len),
    .hy_o    (s_hy)
  );

  bprm_udiv u_udiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_valid),
    .len_i   (s_len),
    .hy_i    (s_hy),
    .valid_o (d_valid),
    .u_o     (d_u)
  );

  bprm_power u_power (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .order_i (order_q),
    .valid_i (d_valid),
    .u_i     (d_u),
    .valid_o (p_valid),
    .p_o     (p_pow)
  );

  bprm_norm u_norm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .cfg_i        (ncfg),
    .valid_i      (p_valid),
    .p_i          (p_pow),
    .valid_o      (out_valid_o),
    .intensity_o  (intensity_o),
    .zero_range_o (zero_range_o)
  );

  `BPRM_ASSERT_IMP(a_zero_range_dark, out_valid_o && zero_range_o, intensity_o == '0)
  `BPRM_ASSERT_IMP(a_stall_needs_held_out, in_stall_o, out_valid_o && out_stall_i)
  `BPRM_ASSERT_NXT(a_order_write, wr_ord, order_q == $past(pwdata[ORDER_W-1:0]))

endmodule
